// File: hdl/hpc_pkg.sv
// Shared widths, codes and the direction classifier for the hand placement block.
package hpc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 12;
  localparam int MAG_W      = 11;
  localparam int Q_W        = 16;
  localparam int QBITS      = 15;
  localparam int ALPHA_W    = 9;
  localparam int THR_W      = 15;
  localparam int ACC_W      = 26;
  localparam int DS_W       = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int CNT_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_MIN = 2'd0,
    CFG_ALPHA     = 2'd1,
    CFG_ENTER_THR = 2'd2,
    CFG_EXIT_THR  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PR_OK         = 4'd0,
    PR_LEFT       = 4'd1,
    PR_RIGHT      = 4'd2,
    PR_UP         = 4'd3,
    PR_DOWN       = 4'd4,
    PR_UP_LEFT    = 4'd5,
    PR_UP_RIGHT   = 4'd6,
    PR_DOWN_LEFT  = 4'd7,
    PR_DOWN_RIGHT = 4'd8,
    PR_NO_HANDS   = 4'd9
  } prompt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EMA,
    ST_CLASS,
    ST_DONE
  } state_t;

  // Diagonals first, then horizontal, then vertical.
  function automatic prompt_t classify(input logic signed [Q_W-1:0] fx,
                                       input logic signed [Q_W-1:0] fy,
                                       input logic [THR_W-1:0] thr);
    logic signed [Q_W:0] x17, y17, pthr, nthr;
    logic xh, xl, yh, yl;
    prompt_t p;
    x17  = {fx[Q_W-1], fx};
    y17  = {fy[Q_W-1], fy};
    pthr = {2'b00, thr};
    nthr = -pthr;
    xh = x17 > pthr;
    xl = x17 < nthr;
    yh = y17 > pthr;
    yl = y17 < nthr;
    if (!xh && !xl && !yh && !yl) p = PR_OK;
    else if (yl && xl)            p = PR_UP_RIGHT;
    else if (yl && xh)            p = PR_UP_LEFT;
    else if (yh && xl)            p = PR_DOWN_RIGHT;
    else if (yh && xh)            p = PR_DOWN_LEFT;
    else if (xh)                  p = PR_LEFT;
    else if (xl)                  p = PR_RIGHT;
    else if (yh)                  p = PR_DOWN;
    else                          p = PR_UP;
    return p;
  endfunction

endpackage

// File: hdl/hpc_if.sv
// Valid/ready channel interfaces for sensor beats and classifier result beats.
interface hpc_in_if import hpc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_top_right;
  logic [SAMPLE_W-1:0] sample_bottom_right;
  logic [SAMPLE_W-1:0] sample_bottom_left;
  logic [SAMPLE_W-1:0] sample_top_left;

  modport source (output valid, sample_top_right, sample_bottom_right,
                  sample_bottom_left, sample_top_left, input ready);
  modport sink (input valid, sample_top_right, sample_bottom_right,
                sample_bottom_left, sample_top_left, output ready);
endinterface

interface hpc_out_if import hpc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [3:0]            prompt;
  logic                  correcting;
  logic signed [Q_W-1:0] filt_x;
  logic signed [Q_W-1:0] filt_y;
  logic [SUM_W-1:0]      total_force;

  modport source (output valid, prompt, correcting, filt_x, filt_y, total_force,
                  input ready);
  modport sink (input valid, prompt, correcting, filt_x, filt_y, total_force,
                output ready);
endinterface

// File: hdl/hpc_div.sv
// Bit-serial restoring divider: rounded Q1.14 ratio of imbalance over total force.
module hpc_div import hpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MAG_W-1:0]      mag,
  input  logic                  neg,
  input  logic [SUM_W-1:0]      den,
  output logic                  done,
  output logic signed [Q_W-1:0] quo
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [QBITS-1:0] sh_r, sh_nxt;
  logic [QBITS-1:0] q_r, q_nxt;
  logic [SUM_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;

  logic [SUM_W:0]   trial, diff;
  logic             ge;
  logic [Q_W-1:0]   qm;

  // dividend = mag * 2^14 + den/2; its top bits (mag >> 1) are already below den
  assign trial = {rem_r, sh_r[QBITS-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {2'b00, mag[MAG_W-1:1]};
      sh_nxt   = {mag[0], 3'b000, den[SUM_W-1:1]};
      q_nxt    = '0;
      den_nxt  = den;
      neg_nxt  = neg;
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      rem_nxt = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      sh_nxt  = {sh_r[QBITS-2:0], 1'b0};
      q_nxt   = {q_r[QBITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QBITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // zero total (gate at zero) gives a zero ratio
  assign qm   = zero_r ? '0 : {1'b0, q_r};
  assign quo  = neg_r ? -qm : qm;
  assign done = done_r;

endmodule

// File: hdl/hpc_ema.sv
// Bit-serial EMA update: f + alpha*(x - f)/256, shift-add over the alpha bits.
module hpc_ema import hpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ALPHA_W-1:0]    alpha,
  input  logic signed [Q_W-1:0] x,
  input  logic signed [Q_W-1:0] f,
  output logic                  done,
  output logic signed [Q_W-1:0] res
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ALPHA_W-1:0]      a_r, a_nxt;
  logic signed [DS_W-1:0]  ds_r, ds_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic [Q_W:0]       d17;
  logic [ACC_W-1:0]   mag;
  logic [ACC_W-1:0]   rnd;
  logic [ACC_W-9:0]   qm;
  logic [Q_W-1:0]     qm16;

  assign d17 = {x[Q_W-1], x} - {f[Q_W-1], f};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    ds_nxt   = ds_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = (alpha > ALPHA_W'(256)) ? ALPHA_W'(256) : alpha;
      ds_nxt   = {{(DS_W-Q_W-1){d17[Q_W]}}, d17};
      acc_nxt  = {{(ACC_W-Q_W-8){f[Q_W-1]}}, f, 8'h00};
    end else if (busy_r) begin
      if (a_r[0]) acc_nxt = acc_r + {ds_r[DS_W-1], ds_r};
      ds_nxt  = ds_r <<< 1;
      a_nxt   = a_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ALPHA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    ds_r  <= ds_nxt;
    acc_r <= acc_nxt;
  end

  // divide by 256, round half away from zero
  assign mag  = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign rnd  = mag + ACC_W'(128);
  assign qm   = rnd[ACC_W-1:8];
  assign qm16 = qm[Q_W-1:0];
  assign res  = acc_r[ACC_W-1] ? -qm16 : qm16;
  assign done = done_r;

endmodule

// File: hdl/hand_placement_classifier.sv
// Top level of the hand placement classifier: sequencer, state and channel registers.
//
// Takes one beat of four corner force samples and returns one result beat with the
// total force, the smoothed Q1.14 X/Y imbalances and a latched direction prompt.
// A total below force_min reports "no hands", drops correction mode and empties the
// filter. Otherwise two bit-serial dividers (one per axis) form the ratios, one
// quotient bit per cycle; then, once the filter is primed, two bit-serial EMA units
// run over the 9 alpha bits (the first item after the filter was emptied loads the
// ratio directly). A finished item waits in ST_DONE until the previous result beat
// has left. Items are handled one at a time; the result beat sits in an output
// register, so the next input beat is taken while a result still waits.
// Config writes (cfg_we, cfg_idx, cfg_data) apply at the clock edge and must only
// occur while the block is idle.
module hand_placement_classifier import hpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hpc_in_if.sink                in_ch,
  hpc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [SUM_W-1:0]   force_min_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [THR_W-1:0]   enter_thr_r;
  logic [THR_W-1:0]   exit_thr_r;

  // sequencer
  state_t state_r, state_nxt;
  logic   in_ready, div_start, ema_start, out_load;

  // captured samples and totals
  logic [SAMPLE_W-1:0] tr_r, br_r, bl_r, tl_r;
  logic [SUM_W-1:0]    sum_r;
  logic                gate_r;

  // filter and hysteresis state
  logic                  fv_r;
  logic signed [Q_W-1:0] sx_r, sy_r;
  logic                  corr_r;
  prompt_t               held_r;

  // output register
  logic                  out_valid_r;
  prompt_t               out_prompt_r;
  logic                  out_corr_r;
  logic signed [Q_W-1:0] out_fx_r, out_fy_r;
  logic [SUM_W-1:0]      out_tot_r;

  // datapath
  logic [SUM_W-1:0]      right_sum, left_sum, top_sum, bot_sum, total;
  logic [SUM_W:0]        dx, dy;
  logic [MAG_W-1:0]      mag_x, mag_y;
  logic                  below_gate;
  logic                  divx_done, divy_done;
  logic signed [Q_W-1:0] qx, qy;
  logic                  emax_done, emay_done;
  logic signed [Q_W-1:0] ex, ey;
  logic [Q_W:0]          ax, ay;
  logic                  past_enter, under_exit;
  logic                  out_free;

  assign right_sum  = SUM_W'(tr_r) + SUM_W'(br_r);
  assign left_sum   = SUM_W'(bl_r) + SUM_W'(tl_r);
  assign top_sum    = SUM_W'(tr_r) + SUM_W'(tl_r);
  assign bot_sum    = SUM_W'(br_r) + SUM_W'(bl_r);
  assign total      = right_sum + left_sum;
  assign dx         = {1'b0, right_sum} - {1'b0, left_sum};
  assign dy         = {1'b0, top_sum} - {1'b0, bot_sum};
  // |d| never exceeds 2046, so 11 bits of magnitude suffice
  assign mag_x      = dx[SUM_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
  assign mag_y      = dy[SUM_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
  assign below_gate = total < force_min_r;

  hpc_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mag_x),
    .neg   (dx[SUM_W]),
    .den   (total),
    .done  (divx_done),
    .quo   (qx)
  );

  hpc_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mag_y),
    .neg   (dy[SUM_W]),
    .den   (total),
    .done  (divy_done),
    .quo   (qy)
  );

  // qx/qy hold after the divider finishes, so they feed the EMA for its whole run
  hpc_ema u_ema_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ema_start),
    .alpha (alpha_r),
    .x     (qx),
    .f     (sx_r),
    .done  (emax_done),
    .res   (ex)
  );

  hpc_ema u_ema_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ema_start),
    .alpha (alpha_r),
    .x     (qy),
    .f     (sy_r),
    .done  (emay_done),
    .res   (ey)
  );

  // hysteresis tests on the freshly smoothed values
  assign ax = sx_r[Q_W-1] ? -{sx_r[Q_W-1], sx_r} : {1'b0, sx_r};
  assign ay = sy_r[Q_W-1] ? -{sy_r[Q_W-1], sy_r} : {1'b0, sy_r};
  assign past_enter = (ax > {2'b00, enter_thr_r}) || (ay > {2'b00, enter_thr_r});
  assign under_exit = (ax < {2'b00, exit_thr_r}) && (ay < {2'b00, exit_thr_r});

  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = below_gate ? ST_DONE : ST_DIV;
      ST_DIV:   if (divx_done) state_nxt = fv_r ? ST_EMA : ST_CLASS;
      ST_EMA:   if (emax_done) state_nxt = ST_CLASS;
      ST_CLASS: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ema_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_SUM:   div_start = !below_gate;
      ST_DIV:   ema_start = divx_done && fv_r;
      ST_DONE:  out_load  = out_free;
      default:  ;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      force_min_r <= SUM_W'(20);
      alpha_r     <= ALPHA_W'(51);
      enter_thr_r <= THR_W'(2458);
      exit_thr_r  <= THR_W'(1638);
      fv_r        <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      corr_r      <= 1'b0;
      held_r      <= PR_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_FORCE_MIN: force_min_r <= cfg_data[SUM_W-1:0];
          CFG_ALPHA:     alpha_r     <= cfg_data[ALPHA_W-1:0];
          CFG_ENTER_THR: enter_thr_r <= cfg_data[THR_W-1:0];
          CFG_EXIT_THR:  exit_thr_r  <= cfg_data[THR_W-1:0];
          default:       ;
        endcase
      end

      // no hands: leave correction, empty the filter
      if (state_r == ST_SUM && below_gate) begin
        corr_r <= 1'b0;
        held_r <= PR_NO_HANDS;
        fv_r   <= 1'b0;
      end

      // empty filter loads the ratio directly
      if (state_r == ST_DIV && divx_done && divy_done && !fv_r) begin
        sx_r <= qx;
        sy_r <= qy;
        fv_r <= 1'b1;
      end

      if (state_r == ST_EMA && emax_done && emay_done) begin
        sx_r <= ex;
        sy_r <= ey;
      end

      if (state_r == ST_CLASS) begin
        if (!corr_r) begin
          if (past_enter) begin
            corr_r <= 1'b1;
            held_r <= classify(sx_r, sy_r, enter_thr_r);
          end else begin
            held_r <= PR_OK;
          end
        end else if (under_exit) begin
          corr_r <= 1'b0;
          held_r <= PR_OK;
        end else if (past_enter) begin
          held_r <= classify(sx_r, sy_r, enter_thr_r);
        end
      end

      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end

    // payload registers
    if (in_ready && in_ch.valid) begin
      tr_r <= in_ch.sample_top_right;
      br_r <= in_ch.sample_bottom_right;
      bl_r <= in_ch.sample_bottom_left;
      tl_r <= in_ch.sample_top_left;
    end
    if (state_r == ST_SUM) begin
      sum_r  <= total;
      gate_r <= below_gate;
    end
    if (out_load) begin
      out_prompt_r <= held_r;
      out_corr_r   <= corr_r;
      out_fx_r     <= gate_r ? '0 : sx_r;
      out_fy_r     <= gate_r ? '0 : sy_r;
      out_tot_r    <= sum_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prompt      = out_prompt_r;
  assign out_ch.correcting  = out_corr_r;
  assign out_ch.filt_x      = out_fx_r;
  assign out_ch.filt_y      = out_fy_r;
  assign out_ch.total_force = out_tot_r;

endmodule
